// ===== rtl/core/nwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// nwpt_pkg
// Shared constants, codes and controller/datapath types for the neighbour
// wake-up phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package nwpt_pkg;

  localparam int DEF_TABLE_ENTRIES = 8;
  localparam int DEF_ADDRESS_BITS  = 64;
  localparam int DEF_TIME_BITS     = 32;

  // Field widths of the stream items
  localparam int FUNC_W    = 2;
  localparam int ADDR_W    = 64;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ONTIME_W  = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  // Input tdata layout, lowest bit first
  localparam int IN_FUNC_LSB  = 0;
  localparam int IN_ADDR_LSB  = IN_FUNC_LSB + FUNC_W;
  localparam int IN_STIME_LSB = IN_ADDR_LSB + ADDR_W;
  localparam int IN_PHASE_LSB = IN_STIME_LSB + TIME_W;
  localparam int IN_NOW_LSB   = IN_PHASE_LSB + TIME_W;
  localparam int IN_USED_W    = IN_NOW_LSB + TIME_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_HIT_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_WAKE_LSB   = OUT_HIT_LSB + 1;
  localparam int OUT_USED_W     = OUT_WAKE_LSB + TIME_W;
  localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO_ON_TIME = 1'd1;

  typedef struct packed {
    logic                load;       // capture input item, restart scan
    logic                scan;       // walk the table
    logic                wr;         // write record
    logic                wr_new;     // write goes to the free slot and sets valid
    logic                div_start;  // start the remainder unit
    logic                res_load;   // load the output register
    logic                res_wake;   // output carries the computed wake time
    logic                res_hit;
    logic [STATUS_W-1:0] res_status;
  } nwpt_cmd_t;

  typedef struct packed {
    logic              scan_done;
    logic              div_done;
    logic              hit;
    logic              free;
    logic              out_free;
    logic [FUNC_W-1:0] func;
  } nwpt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/nwpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// nwpt_ctrl
// Sequencer: accept, scan the table, decide, remainder, deliver the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nwpt_ctrl
  import nwpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire nwpt_sts_t sts,
  output nwpt_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]          state, state_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                res_hit, res_hit_next;
  logic                res_wake, res_wake_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    res_wake   <= res_wake_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_hit_next    = res_hit;
    res_wake_next   = res_wake;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_hit     = res_hit;
    cmd.res_wake    = res_wake;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_next = ST_NOT_FOUND;
        res_hit_next    = 1'b0;
        res_wake_next   = 1'b0;
        state_next      = S_FINISH;
        priority if (sts.func == FUNC_REGISTER) begin
          if (sts.hit) begin
            cmd.wr          = 1'b1;
            res_status_next = ST_FOUND;
            res_hit_next    = 1'b1;
          end else if (sts.free) begin
            cmd.wr          = 1'b1;
            cmd.wr_new      = 1'b1;
            res_status_next = ST_INSERTED;
          end else begin
            res_status_next = ST_FULL;
          end
        end else if (sts.func == FUNC_UPDATE) begin
          if (sts.hit) begin
            cmd.wr          = 1'b1;
            res_status_next = ST_FOUND;
            res_hit_next    = 1'b1;
          end
        end else if (sts.func == FUNC_LOOKUP) begin
          if (sts.hit) begin
            cmd.div_start   = 1'b1;
            res_status_next = ST_FOUND;
            res_hit_next    = 1'b1;
            res_wake_next   = 1'b1;
            state_next      = S_DIV;
          end
        end else begin
          // unused operation code: answer not found
          res_status_next = ST_NOT_FOUND;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/nwpt_dp.sv =====
// ----------------------------------------------------------------------------
// nwpt_dp
// Datapath: configuration registers, entry store with scan compare,
// bit-serial remainder unit, wake time adder and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nwpt_dp
  import nwpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS,
  parameter int TIME_BITS     = DEF_TIME_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [ADDR_W-1:0]     in_addr,
  input  wire logic [TIME_W-1:0]     in_stime,
  input  wire logic [TIME_W-1:0]     in_phase,
  input  wire logic [TIME_W-1:0]     in_now,
  input  wire nwpt_cmd_t             cmd,
  output nwpt_sts_t                  sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_hit,
  output logic [TIME_W-1:0]          out_wake
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int DCNT_W = $clog2(TIME_BITS + 1);
  localparam int WW     = (TIME_BITS > ONTIME_W + 1) ? TIME_BITS : ONTIME_W + 1;

  // configuration
  logic [TIME_BITS-1:0] period;
  logic [ONTIME_W-1:0]  on_time;

  // captured item
  logic [FUNC_W-1:0]       func_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [TIME_BITS-1:0]    stime_q;
  logic [TIME_BITS-1:0]    phase_q;
  logic [TIME_BITS-1:0]    now_q;

  // entry store
  logic [TABLE_ENTRIES-1:0] valid;
  logic [ADDRESS_BITS-1:0]  mem_addr  [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]     mem_stime [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]     mem_phase [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0]  rd_addr;
  logic [TIME_BITS-1:0]     rd_stime;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_vld;
  logic [CNT_W-1:0]         scan_cnt;
  logic                     hit_q, free_q;
  logic [IDX_W-1:0]         hit_idx, free_idx;
  logic [TIME_BITS-1:0]     match_time;
  logic [IDX_W-1:0]         wr_idx;
  logic                     scan_issue;

  // remainder unit
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dvd;
  logic [DCNT_W-1:0]    div_cnt;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   trial_sub;
  logic [WW-1:0]        wake_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= TIME_BITS'(1024);
      on_time <= ONTIME_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD: period  <= cfg_data[TIME_BITS-1:0];
        REG_RADIO_ON_TIME: on_time <= cfg_data[ONTIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= in_func;
      addr_q  <= in_addr[ADDRESS_BITS-1:0];
      stime_q <= in_stime[TIME_BITS-1:0];
      phase_q <= in_phase[TIME_BITS-1:0];
      now_q   <= in_now[TIME_BITS-1:0];
    end
  end

  // Scan: one read issued per cycle, compared the cycle after on the
  // registered read data. First match and first free slot win.
  assign scan_issue = cmd.scan && (scan_cnt < CNT_W'(TABLE_ENTRIES));
  assign wr_idx     = cmd.wr_new ? free_idx : hit_idx;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_addr[wr_idx]  <= addr_q;
      mem_stime[wr_idx] <= stime_q;
      mem_phase[wr_idx] <= phase_q;
    end
    if (scan_issue) begin
      rd_addr  <= mem_addr[scan_cnt[IDX_W-1:0]];
      rd_stime <= mem_stime[scan_cnt[IDX_W-1:0]];
      rd_idx   <= scan_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld   <= 1'b0;
      scan_cnt <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      if (cmd.wr && cmd.wr_new) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.load) begin
        rd_vld   <= 1'b0;
        scan_cnt <= '0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        rd_vld <= scan_issue;
        if (scan_issue) begin
          scan_cnt <= scan_cnt + CNT_W'(1);
        end
        if (rd_vld) begin
          if (valid[rd_idx] && (rd_addr == addr_q) && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (!valid[rd_idx] && !free_q) begin
            free_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && valid[rd_idx] && (rd_addr == addr_q) && !hit_q) begin
      hit_idx    <= rd_idx;
      match_time <= rd_stime;
    end
    if (rd_vld && !valid[rd_idx] && !free_q) begin
      free_idx <= rd_idx;
    end
  end

  // Restoring remainder, one dividend bit per cycle. A zero period leaves
  // the dividend itself in the remainder, as required.
  assign trial     = {rem, dvd[TIME_BITS-1]};
  assign trial_sub = trial - {1'b0, period};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DCNT_W'(TIME_BITS);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      dvd <= match_time - now_q;
    end else if (div_cnt != '0) begin
      rem <= trial_sub[TIME_BITS] ? trial[TIME_BITS-1:0] : trial_sub[TIME_BITS-1:0];
      dvd <= {dvd[TIME_BITS-2:0], 1'b0};
    end
  end

  assign wake_sum = WW'(now_q) + WW'(rem) - WW'({on_time, 1'b0});

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_status;
      out_hit    <= cmd.res_hit;
      out_wake   <= cmd.res_wake ? TIME_W'(wake_sum[TIME_BITS-1:0]) : '0;
    end
  end

  always_comb begin
    sts           = '0;
    sts.scan_done = (scan_cnt == CNT_W'(TABLE_ENTRIES)) && !rd_vld;
    sts.div_done  = (div_cnt == '0);
    sts.hit       = hit_q;
    sts.free      = free_q;
    sts.out_free  = !out_valid || out_ready;
    sts.func      = func_q;
  end

  a_res_room : assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_new_needs_free : assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && cmd.wr_new) |-> (free_q && !hit_q && !valid[free_idx]))
    else $error("insert without a free slot");

  a_renew_needs_hit : assert property (@(posedge clk) disable iff (rst)
    (cmd.wr && !cmd.wr_new) |-> (hit_q && valid[hit_idx]))
    else $error("renew without a matching entry");

  a_div_lookup : assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (hit_q && func_q == FUNC_LOOKUP))
    else $error("remainder started outside a lookup hit");

  a_div_count : assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |=> (div_cnt == $past(div_cnt) - DCNT_W'(1)))
    else $error("remainder counter skipped");

endmodule

`default_nettype wire

// ===== rtl/core/neighbor_wakeup_phase_table_unit.sv =====
// ----------------------------------------------------------------------------
// neighbor_wakeup_phase_table_unit
// Neighbour table with register, update and lookup operations; lookup gives
// the expected wake time from sample time, current time, period and on-time.
// ----------------------------------------------------------------------------
//  channel   direction  transfer                   contents
//  s_axis    in         s_axis_tvalid&tready       func, peer_address,
//                                                  sample_time, phase_value,
//                                                  now_time
//  m_axis    out        m_axis_tvalid&tready       status, hit, wake_time
//  cfg       in         cfg_we                     0 sample_period,
//                                                  1 radio_on_time
//
//  One item at a time. The table scan (one entry a cycle) and, for a lookup
//  that hits, the bit-serial remainder set the latency.
//  The output register frees the block once the result is loaded; a stalled
//  m_axis holds the next result in the finish step until the slot drains.
//  Synchronous reset empties the table and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_wakeup_phase_table_unit
  import nwpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS,
  parameter int TIME_BITS     = DEF_TIME_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // func, peer_address, sample_time, phase_value, now_time, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status, hit, wake_time, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  nwpt_cmd_t           cmd;
  nwpt_sts_t           sts;
  logic [STATUS_W-1:0] out_status;
  logic                out_hit;
  logic [TIME_W-1:0]   out_wake;

  nwpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nwpt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_BITS  (ADDRESS_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_func    (s_axis_tdata[IN_FUNC_LSB +: FUNC_W]),
    .in_addr    (s_axis_tdata[IN_ADDR_LSB +: ADDR_W]),
    .in_stime   (s_axis_tdata[IN_STIME_LSB +: TIME_W]),
    .in_phase   (s_axis_tdata[IN_PHASE_LSB +: TIME_W]),
    .in_now     (s_axis_tdata[IN_NOW_LSB +: TIME_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_hit    (out_hit),
    .out_wake   (out_wake)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_wake, out_hit, out_status});

endmodule

`default_nettype wire

// ===== dv/tb_neighbor_wakeup_phase_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_neighbor_wakeup_phase_table_unit
// Self-checking bench for the neighbour wake-up phase table. A directed table
// covers empty and full tables, renew, update, the unused operation code and
// the wrap of the wake time. Random phases follow, each with its own period
// and on-time and one of four patterns of sender gaps and receiver stalls.
// Every result is checked against a known value or a behavioural table copy.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_neighbor_wakeup_phase_table_unit
  import nwpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                NB_ENTRIES  = DEF_TABLE_ENTRIES;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int                DRAIN_WAIT  = 60;
  localparam int                DRAIN_LIMIT = 20000;
  localparam int                RAND_PHASES = 6;
  localparam int                PHASE_ITEMS = 205;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stime;
    logic [TIME_W-1:0] phase;
    logic [TIME_W-1:0] now;
  } nb_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [TIME_W-1:0]   wake;
  } nb_result_t;

  typedef struct packed {
    nb_op_t     op;
    logic       fixed;   // result below is known up front
    nb_result_t res;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  // func, address, sample, phase, now; then known result where it is obvious
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{'{FUNC_LOOKUP,   64'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_UPDATE,   '1, '1, '1, '1},             1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_UNUSED,   64'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_REGISTER, 64'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{ST_INSERTED, 1'b0, 32'h0}},
    '{'{FUNC_REGISTER, '1, '1, '1, 32'h0},          1'b1, '{ST_INSERTED, 1'b0, 32'h0}},
    '{'{FUNC_REGISTER, 64'h0, 32'd1000, 32'd77, '1}, 1'b1, '{ST_FOUND, 1'b1, 32'h0}},
    '{'{FUNC_LOOKUP,   64'h0, 32'h0, 32'h0, 32'd1000}, 1'b1, '{ST_FOUND, 1'b1, 32'd936}},
    '{'{FUNC_LOOKUP,   '1, 32'h0, 32'h0, '1},       1'b0, '0},
    '{'{FUNC_UPDATE,   '1, 32'd12345, 32'd5, 32'h0}, 1'b1, '{ST_FOUND, 1'b1, 32'h0}},
    '{'{FUNC_LOOKUP,   '1, 32'h0, 32'h0, 32'h0},    1'b0, '0},
    '{'{FUNC_UNUSED,   '1, '1, '1, '1},             1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_REGISTER, 64'h0123_4567_89AB_CDEF, 32'h8000_0000, 32'h1, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFF, 32'h2, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'h8000_0000_0000_0000, 32'h0000_0400, 32'h3, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'h0000_0000_0000_0001, 32'h0000_03FF, 32'h4, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'h5555_5555_5555_5555, 32'h5555_5555, 32'h5, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h6, 32'h0}, 1'b0, '0},
    '{'{FUNC_REGISTER, 64'h1234_0000_0000_5678, 32'h1, 32'h1, 32'h0}, 1'b1,
      '{ST_FULL, 1'b0, 32'h0}},
    '{'{FUNC_UPDATE,   64'h1234_0000_0000_5678, 32'h1, 32'h1, 32'h0}, 1'b1,
      '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_LOOKUP,   64'h8000_0000_0000_0000, 32'h0, 32'h0, 32'h8000_0000}, 1'b0, '0},
    '{'{FUNC_LOOKUP,   64'h0123_4567_89AB_CDEE, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{ST_NOT_FOUND, 1'b0, 32'h0}},
    '{'{FUNC_REGISTER, 64'h5555_5555_5555_5555, '1, 32'h9, 32'h0}, 1'b0, '0},
    '{'{FUNC_LOOKUP,   64'h5555_5555_5555_5555, 32'h0, 32'h0, 32'h1}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // func, peer_address, sample_time, phase_value, now_time, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status, hit, wake_time, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // behavioural copy of the table and its registers
  logic                nb_valid [NB_ENTRIES];
  logic [ADDR_W-1:0]   nb_addr  [NB_ENTRIES];
  logic [TIME_W-1:0]   nb_stime [NB_ENTRIES];
  logic [TIME_W-1:0]   nb_phase [NB_ENTRIES];
  logic [TIME_W-1:0]   cur_period  = 32'd1024;
  logic [ONTIME_W-1:0] cur_on_time = 16'd32;

  nb_result_t wake_result_q [$];
  int         mismatches     = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  neighbor_wakeup_phase_table_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Apply one operation to the table copy and return the result it gives.
  function automatic nb_result_t table_op_result(input nb_op_t op);
    nb_result_t  res;
    int          hit_idx;
    int          free_idx;
    logic [31:0] diff;
    logic [31:0] wait_ticks;
    res      = '{ST_NOT_FOUND, 1'b0, 32'h0};
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < NB_ENTRIES; i++) begin
      if (nb_valid[i] && nb_addr[i] == op.addr && hit_idx < 0) hit_idx = i;
      if (!nb_valid[i] && free_idx < 0) free_idx = i;
    end
    case (op.func)
      FUNC_REGISTER, FUNC_UPDATE: begin
        if (hit_idx >= 0) begin
          nb_stime[hit_idx] = op.stime;
          nb_phase[hit_idx] = op.phase;
          res.status = ST_FOUND;
          res.hit    = 1'b1;
        end else if (op.func == FUNC_REGISTER) begin
          if (free_idx >= 0) begin
            nb_valid[free_idx] = 1'b1;
            nb_addr[free_idx]  = op.addr;
            nb_stime[free_idx] = op.stime;
            nb_phase[free_idx] = op.phase;
            res.status = ST_INSERTED;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      FUNC_LOOKUP: begin
        if (hit_idx >= 0) begin
          diff = nb_stime[hit_idx] - op.now;
          // a zero period leaves the difference as it is
          wait_ticks = (cur_period != 0) ? diff % cur_period : diff;
          res.wake   = op.now + wait_ticks - (32'(cur_on_time) << 1);
          res.status = ST_FOUND;
          res.hit    = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] random_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly addresses that are in the table, some near misses, some noise.
  function automatic nb_op_t random_op();
    nb_op_t op;
    int     pick;
    int     slot;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op.func = FUNC_REGISTER;
    else if (pick < 50) op.func = FUNC_UPDATE;
    else if (pick < 90) op.func = FUNC_LOOKUP;
    else                op.func = FUNC_UNUSED;
    slot = $urandom_range(0, NB_ENTRIES - 1);
    pick = $urandom_range(0, 99);
    if (pick < 55 && nb_valid[slot])
      op.addr = nb_addr[slot];
    else if (pick < 70 && nb_valid[slot])
      op.addr = nb_addr[slot] ^ (64'd1 << $urandom_range(0, ADDR_W - 1));
    else
      op.addr = {$urandom, $urandom};
    op.stime = random_ticks();
    op.phase = $urandom;
    op.now   = random_ticks();
    return op;
  endfunction

  // Present one operation and queue its result once the transfer is made.
  task automatic send_op(input nb_op_t op, input logic fixed, input nb_result_t fixed_res);
    logic [IN_DATA_W-1:0] word;
    nb_result_t           res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[IN_FUNC_LSB  +: FUNC_W] = op.func;
    word[IN_ADDR_LSB  +: ADDR_W] = op.addr;
    word[IN_STIME_LSB +: TIME_W] = op.stime;
    word[IN_PHASE_LSB +: TIME_W] = op.phase;
    word[IN_NOW_LSB   +: TIME_W] = op.now;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    res = table_op_result(op);
    wake_result_q.push_back(fixed ? fixed_res : res);
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (wake_result_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (wake_result_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", wake_result_q.size()));
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_SAMPLE_PERIOD) cur_period = data;
    else                          cur_on_time = data[ONTIME_W-1:0];
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] period,
                            input logic [CFG_DATA_W-1:0] on_time);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_RADIO_ON_TIME, on_time);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    nb_result_t got;
    nb_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.hit    = m_axis_tdata[OUT_HIT_LSB];
        got.wake   = m_axis_tdata[OUT_WAKE_LSB +: TIME_W];
        if (wake_result_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %0h", got));
        end else begin
          want = wake_result_q.pop_front();
          if (got.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.hit !== want.hit)
            flag_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
          if (got.wake !== want.wake)
            flag_mismatch($sformatf("wake_time %08h, want %08h", got.wake, want.wake));
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < NB_ENTRIES; i++) begin
      nb_valid[i] = 1'b0;
      nb_addr[i]  = '0;
      nb_stime[i] = '0;
      nb_phase[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs on the reset values of the registers
    for (int r = 0; r < DIR_ROWS; r++)
      send_op(directed_rows[r].op, directed_rows[r].fixed, directed_rows[r].res);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_timing(32'h0, 32'h0);
        1: set_timing(32'h1, 32'hFFFF_FFFF);
        2: set_timing(32'hFFFF_FFFF, $urandom);
        3: set_timing($urandom_range(1, 5000), $urandom);
        4: set_timing($urandom, $urandom_range(0, 65535));
        default: set_timing($urandom_range(1, 64), $urandom);
      endcase
      // idle pattern: none, sender, receiver, both
      send_idle_pct  = (p % 4 == 1) ? 49 : (p % 4 == 3) ? 26 : 0;
      recv_stall_pct = (p % 4 == 2) ? 49 : (p % 4 == 3) ? 26 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_op(random_op(), 1'b0, '0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/nwpt_pkg.sv
rtl/core/nwpt_ctrl.sv
rtl/core/nwpt_dp.sv
rtl/core/neighbor_wakeup_phase_table_unit.sv
dv/tb_neighbor_wakeup_phase_table_unit.sv
